// ===== rtl/mep_pkg.sv =====
// ---------------------------------------------------------------------------
// mep_pkg
// Shared constants, widths and types of the mandelbrot escape-time pixel block.
// ---------------------------------------------------------------------------
package mep_pkg;

  localparam int FRAC_BITS = 28;

  // z parts and c parts, |v| <= 2 with fraction bits
  localparam int MUL_W  = FRAC_BITS + 3;
  // scaled product of two MUL_W operands, |p| <= 4
  localparam int PROD_W = FRAC_BITS + 4;
  // new z before the bound check
  localparam int Z_W    = FRAC_BITS + 6;
  // sum of the two squares
  localparam int SUM_W  = PROD_W + 1;

  // divider: 18-bit numerator scaled by 2^FRAC_BITS
  localparam int NUM_W  = 18;
  localparam int DVD_W  = NUM_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  localparam logic signed [MUL_W-1:0] C_ONE  = MUL_W'(1) << FRAC_BITS;
  localparam logic signed [MUL_W-1:0] C_TWO  = MUL_W'(2) << FRAC_BITS;
  localparam logic signed [Z_W-1:0]   Z_TWO  = Z_W'(2) << FRAC_BITS;
  localparam logic signed [Z_W-1:0]   Z_MTWO = -Z_TWO;
  localparam logic signed [SUM_W-1:0] S_FOUR = SUM_W'(4) << FRAC_BITS;

  localparam int CFG_AW = 4;

  // register index codes, taken from paddr[3:2]
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAXIT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_R,
    ST_DIV_I,
    ST_MUL_RI,
    ST_UPD,
    ST_SQR_I,
    ST_TEST,
    ST_GRAY,
    ST_GRAY_W,
    ST_FIN
  } mep_state_t;

endpackage

// ===== rtl/mandelbrot_escape_pixel.sv =====
// Two bit-serial divisions of FRAC_BITS+18 steps each map the pixel to c, then each
//   iteration takes three multiplier passes, and a third division gives the gray level
//   unless the limit is zero
// in_tready is high only while idle, and a new pixel is taken while the previous
//   result still waits on the output
// reset: synchronous active-low rst_n, registers return to 640/480/256
// ---------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluator for one pixel: maps the pixel to c, iterates z*z + c
// with a shared multiplier and returns the escape index and a gray level.
// ---------------------------------------------------------------------------
module mandelbrot_escape_pixel (
  input  logic                        clk,
  input  logic                        rst_n,
  // stream in
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,    // pixel_x[15:0], pixel_y[31:16]
  // stream out
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,   // escape_count[15:0], gray_level[23:16]
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mep_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int F = mep_pkg::FRAC_BITS;

  // configuration registers
  logic [15:0] width_r, height_r, max_it_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd640;
      height_r <= 16'd480;
      max_it_r <= 16'd256;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        mep_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[15:0];
        mep_pkg::REG_HEIGHT: height_r <= cfg_pwdata[15:0];
        mep_pkg::REG_MAXIT:  max_it_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      mep_pkg::REG_WIDTH:  cfg_prdata = {16'd0, width_r};
      mep_pkg::REG_HEIGHT: cfg_prdata = {16'd0, height_r};
      mep_pkg::REG_MAXIT:  cfg_prdata = {16'd0, max_it_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // clamping of the pixel to the image
  logic [15:0] w_eff, h_eff, px_in, py_in, px_cl, py_cl;

  assign w_eff = (width_r == 16'd0)  ? 16'd1 : width_r;
  assign h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  assign px_in = in_tdata[15:0];
  assign py_in = in_tdata[31:16];
  assign px_cl = (px_in > w_eff - 16'd1) ? w_eff - 16'd1 : px_in;
  assign py_cl = (py_in > h_eff - 16'd1) ? h_eff - 16'd1 : py_in;

  // shared units
  logic                              div_start, div_done;
  logic [mep_pkg::DVD_W-1:0]         div_dvd, div_q;
  logic [15:0]                       div_den;
  logic signed [mep_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [mep_pkg::PROD_W-1:0] mul_p;

  mep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  mep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sequencer state
  mep_pkg::mep_state_t                state_r, state_nxt;
  logic [15:0]                        py_r, py_nxt;
  logic signed [mep_pkg::MUL_W-1:0]   cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [mep_pkg::MUL_W-1:0]   zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [mep_pkg::PROD_W-1:0]  zr2_r, zr2_nxt, zi2_r, zi2_nxt;
  logic [15:0]                        iter_r, iter_nxt;
  logic [15:0]                        n_r, n_nxt;
  logic [7:0]                         gray_r, gray_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [15:0]                        out_count_r, out_count_nxt;
  logic [7:0]                         out_gray_r, out_gray_nxt;

  logic                               in_acc;
  logic [17:0]                        num_x, num_y;
  logic [23:0]                        n255;
  logic signed [mep_pkg::Z_W-1:0]     zr_new, zi_new;
  logic signed [mep_pkg::SUM_W-1:0]   mag2;
  logic                               out_of_box;

  assign in_tready = (state_r == mep_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign num_x     = {2'b00, px_cl} + {1'b0, px_cl, 1'b0};
  assign num_y     = {1'b0, py_r, 1'b0};
  assign n255      = {n_r, 8'd0} - {8'd0, n_r};

  assign zr_new = mep_pkg::Z_W'(zr2_r) - mep_pkg::Z_W'(zi2_r) + mep_pkg::Z_W'(cr_r);
  assign zi_new = (mep_pkg::Z_W'(mul_p) <<< 1) + mep_pkg::Z_W'(ci_r);
  assign out_of_box = (zr_new > mep_pkg::Z_TWO) || (zr_new < mep_pkg::Z_MTWO) ||
                      (zi_new > mep_pkg::Z_TWO) || (zi_new < mep_pkg::Z_MTWO);
  assign mag2 = mep_pkg::SUM_W'(zr2_r) + mep_pkg::SUM_W'(mul_p);

  always_comb begin
    state_nxt     = state_r;
    py_nxt        = py_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    zr2_nxt       = zr2_r;
    zi2_nxt       = zi2_r;
    iter_nxt      = iter_r;
    n_nxt         = n_r;
    gray_nxt      = gray_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_gray_nxt  = out_gray_r;
    div_start     = 1'b0;
    div_dvd       = {num_x, {F{1'b0}}};
    div_den       = w_eff;
    mul_a         = zr_r;
    mul_b         = zi_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mep_pkg::ST_IDLE: begin
        if (in_acc) begin
          py_nxt    = py_cl;
          div_start = 1'b1;
          state_nxt = mep_pkg::ST_DIV_R;
        end
      end
      mep_pkg::ST_DIV_R: begin
        div_dvd = {num_y, {F{1'b0}}};
        div_den = h_eff;
        if (div_done) begin
          cr_nxt    = $signed({1'b0, div_q[F+1:0]}) - mep_pkg::C_TWO;
          div_start = 1'b1;
          state_nxt = mep_pkg::ST_DIV_I;
        end
      end
      mep_pkg::ST_DIV_I: begin
        if (div_done) begin
          ci_nxt   = $signed({1'b0, div_q[F+1:0]}) - mep_pkg::C_ONE;
          zr_nxt   = '0;
          zi_nxt   = '0;
          zr2_nxt  = '0;
          zi2_nxt  = '0;
          iter_nxt = 16'd0;
          if (max_it_r == 16'd0) begin
            n_nxt     = 16'd0;
            state_nxt = mep_pkg::ST_GRAY;
          end else begin
            state_nxt = mep_pkg::ST_MUL_RI;
          end
        end
      end
      mep_pkg::ST_MUL_RI: begin
        state_nxt = mep_pkg::ST_UPD;
      end
      mep_pkg::ST_UPD: begin
        // mul_p holds zr*zi here
        zr_nxt = zr_new[mep_pkg::MUL_W-1:0];
        zi_nxt = zi_new[mep_pkg::MUL_W-1:0];
        mul_a  = zr_new[mep_pkg::MUL_W-1:0];
        mul_b  = zr_new[mep_pkg::MUL_W-1:0];
        if (out_of_box) begin
          n_nxt     = iter_r;
          state_nxt = mep_pkg::ST_GRAY;
        end else begin
          state_nxt = mep_pkg::ST_SQR_I;
        end
      end
      mep_pkg::ST_SQR_I: begin
        zr2_nxt   = mul_p;
        mul_a     = zi_r;
        mul_b     = zi_r;
        state_nxt = mep_pkg::ST_TEST;
      end
      mep_pkg::ST_TEST: begin
        // squares are kept for the next iteration, zr*zi issued meanwhile
        zi2_nxt = mul_p;
        if (mag2 > mep_pkg::S_FOUR) begin
          n_nxt     = iter_r;
          state_nxt = mep_pkg::ST_GRAY;
        end else if ({1'b0, iter_r} + 17'd1 == {1'b0, max_it_r}) begin
          n_nxt     = max_it_r;
          state_nxt = mep_pkg::ST_GRAY;
        end else begin
          iter_nxt  = iter_r + 16'd1;
          state_nxt = mep_pkg::ST_UPD;
        end
      end
      mep_pkg::ST_GRAY: begin
        div_dvd = mep_pkg::DVD_W'(n255);
        div_den = max_it_r;
        if (max_it_r == 16'd0) begin
          gray_nxt  = 8'd0;
          state_nxt = mep_pkg::ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = mep_pkg::ST_GRAY_W;
        end
      end
      mep_pkg::ST_GRAY_W: begin
        if (div_done) begin
          gray_nxt  = div_q[7:0];
          state_nxt = mep_pkg::ST_FIN;
        end
      end
      mep_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = n_r;
          out_gray_nxt  = gray_r;
          state_nxt     = mep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mep_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mep_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    py_r        <= py_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    zr2_r       <= zr2_nxt;
    zi2_r       <= zi2_nxt;
    n_r         <= n_nxt;
    gray_r      <= gray_nxt;
    out_count_r <= out_count_nxt;
    out_gray_r  <= out_gray_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_gray_r, out_count_r};

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a pixel is in work");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r <= max_it_r)
    else $error("escape count beyond the iteration limit");

  a_full_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && max_it_r != 16'd0 && out_count_r == max_it_r |-> out_gray_r == 8'd255)
    else $error("point inside the set without full gray level");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mep_pkg::ST_TEST || state_r == mep_pkg::ST_UPD |-> iter_r < max_it_r)
    else $error("iteration index past the limit");

endmodule

// ===== rtl/mep_div.sv =====
// ---------------------------------------------------------------------------
// mep_div
// Restoring divider, one quotient bit per cycle, 16-bit nonzero divisor.
// ---------------------------------------------------------------------------
module mep_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mep_pkg::DVD_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      done,
  output logic [mep_pkg::DVD_W-1:0] quotient
);

  logic                       busy_r,  busy_nxt;
  logic                       done_r,  done_nxt;
  logic [mep_pkg::DCNT_W-1:0] cnt_r,   cnt_nxt;
  logic [15:0]                rem_r,   rem_nxt;
  logic [mep_pkg::DVD_W-1:0]  quo_r,   quo_nxt;
  logic [15:0]                den_r,   den_nxt;
  logic [16:0]                trial;
  logic                       ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[mep_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mep_pkg::DCNT_W'(mep_pkg::DVD_W - 1);
      rem_nxt  = 16'd0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      quo_nxt = {quo_r[mep_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/mep_mul.sv =====
// ---------------------------------------------------------------------------
// mep_mul
// Shared fixed-point multiplier, floor(a*b / 2^FRAC_BITS), registered output.
// ---------------------------------------------------------------------------
module mep_mul (
  input  logic                              clk,
  input  logic signed [mep_pkg::MUL_W-1:0]  a,
  input  logic signed [mep_pkg::MUL_W-1:0]  b,
  output logic signed [mep_pkg::PROD_W-1:0] p
);

  logic signed [2*mep_pkg::MUL_W-1:0]  full;
  logic signed [2*mep_pkg::MUL_W-1:0]  scaled;
  logic signed [mep_pkg::PROD_W-1:0]   p_r;

  assign full   = a * b;
  // arithmetic shift rounds toward minus infinity
  assign scaled = full >>> mep_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    p_r <= scaled[mep_pkg::PROD_W-1:0];
  end

  assign p = p_r;

endmodule
